>>> hw/rtl/fsts_pkg.sv
// Shared types, widths and constants of the fixed-step tick scheduler.
package fsts_pkg;

    // Default sizes of the internal time and accumulator registers.
    localparam int TIME_BITS_DEF = 40;
    localparam int ACC_BITS_DEF  = 24;

    // Field widths of the items and registers.
    localparam int NOW_W      = 40;
    localparam int PERIOD_W   = 20;
    localparam int CATCH_W    = 24;
    localparam int SCALE_W    = 16;
    localparam int DELTA_W    = 28;
    localparam int TOTAL_W    = 48;
    localparam int PEND_W     = 24;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd16667;
    localparam logic [CATCH_W-1:0]  CATCH_RST  = 24'd300000;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd256;

    // Saturation limit of the pending step count.
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // Operation code of an input item that restarts the schedule.
    localparam logic OP_RESET = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_PERIOD  = 2'd0,
        REG_MAX_CATCH_UP = 2'd1,
        REG_TIME_SCALE   = 2'd2,
        REG_PAUSED       = 2'd3
    } cfg_reg_t;

    // One tick event.
    typedef struct packed {
        logic             operation;
        logic [NOW_W-1:0] now_us;
    } tick_item_t;

    // One scheduler result.
    typedef struct packed {
        logic               step_taken;
        logic [NOW_W-1:0]   next_due_us;
        logic [DELTA_W-1:0] scaled_delta_us;
        logic [TOTAL_W-1:0] game_time_us;
        logic [TOTAL_W-1:0] unscaled_time_us;
        logic [PEND_W-1:0]  steps_left;
        logic [COUNT_W-1:0] step_count;
    } result_item_t;

endpackage

>>> hw/rtl/fsts_div.sv
// Restoring divider that turns accumulated time into a count of whole steps.
module fsts_div #(
    parameter int ACC_BITS = fsts_pkg::ACC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ACC_BITS-1:0]           dividend,
    input  logic [fsts_pkg::PERIOD_W-1:0] divisor,
    output logic                          done,
    output logic [ACC_BITS-1:0]           quotient
);
    import fsts_pkg::*;

    localparam int CNT_W = $clog2(ACC_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dsr_reg, dsr_next;
    logic [ACC_BITS-1:0] quo_reg, quo_next;

    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    logic              fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[ACC_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ACC_BITS);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quo_next = {quo_reg[ACC_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/fixed_step_tick_scheduler.sv
// A reset event, a tick while disabled, or a paused tick with no step pending goes from
// S_DECIDE straight to S_DONE. A tick that fires an already pending step passes S_FIRE,
// S_DUE and S_TOTAL. A tick that refills the accumulator passes S_ACC, runs the divider in
// S_DIV_START and S_DIV, then fires a step the same way or goes to S_DONE if none is due.
// One item at a time; the next item is taken the cycle after the result is stored.
// Reset (rst_n low, asynchronous) restores the register defaults and clears all scheduler state.
module fixed_step_tick_scheduler #(
    parameter int TIME_BITS = fsts_pkg::TIME_BITS_DEF,
    parameter int ACC_BITS  = fsts_pkg::ACC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_ready,
    input  fsts_pkg::tick_item_t            tick,
    output logic                            result_valid,
    input  logic                            result_ready,
    output fsts_pkg::result_item_t          result,
    input  logic                            wr_en,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [fsts_pkg::CFG_DATA_W-1:0] wr_data
);
    import fsts_pkg::*;

    localparam int LIM_W  = (ACC_BITS > CATCH_W) ? ACC_BITS : CATCH_W;
    localparam int SUM_W  = ((TIME_BITS > ACC_BITS) ? TIME_BITS : ACC_BITS) + 1;
    localparam int QEXT_W = (ACC_BITS > PEND_W) ? ACC_BITS : PEND_W;
    localparam int AP_W   = (ACC_BITS > PERIOD_W) ? ACC_BITS : PERIOD_W;
    localparam int PROD_W = PERIOD_W + SCALE_W;
    localparam logic [LIM_W-1:0] ACC_MAX_L = LIM_W'({ACC_BITS{1'b1}});

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ACC,
        S_DIV_START,
        S_DIV,
        S_FIRE,
        S_DUE,
        S_TOTAL,
        S_DONE
    } state_t;

    // Add a step length to a time stamp, saturating at the largest time value.
    function automatic logic [TIME_BITS-1:0] sat_add_time(
        input logic [TIME_BITS-1:0] t,
        input logic [PERIOD_W-1:0]  d
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS + 1)'(d);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    state_t state_reg, state_next;

    // Configuration registers.
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [CATCH_W-1:0]  catch_reg, catch_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic                paused_reg, paused_next;

    // Scheduler state.
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [PEND_W-1:0]    pend_reg, pend_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] due_reg, due_next;
    logic [TOTAL_W-1:0]   scaled_tot_reg, scaled_tot_next;
    logic [TOTAL_W-1:0]   unscaled_tot_reg, unscaled_tot_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // Current item and intermediate values.
    logic                 op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [DELTA_W-1:0]   delta_reg, delta_next;
    logic                 taken_reg, taken_next;

    // Output register.
    logic         result_valid_reg, result_valid_next;
    result_item_t result_reg, result_next;

    // Divider connection.
    logic                div_start;
    logic                div_done;
    logic [ACC_BITS-1:0] div_quotient;

    // Combinational helpers.
    logic [SCALE_W-1:0]   scale_eff;
    logic [TIME_BITS-1:0] elapsed_w;
    logic [CATCH_W-1:0]   limit;
    logic [LIM_W-1:0]     lim_eff;
    logic [SUM_W-1:0]     acc_sum;
    logic [ACC_BITS-1:0]  acc_clamped;
    logic [QEXT_W-1:0]    quot_ext;
    logic [PEND_W-1:0]    pend_from_div;
    logic                 acc_ge_period;
    logic [ACC_BITS-1:0]  acc_minus;
    logic [PERIOD_W-1:0]  gap;
    logic [PROD_W-1:0]    prod;
    logic [TOTAL_W:0]     unscaled_sum;
    logic [TOTAL_W:0]     scaled_sum;

    fsts_div #(
        .ACC_BITS(ACC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(acc_reg),
        .divisor (period_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    assign div_start = (state_reg == S_DIV_START);

    // Elapsed time, clamped at zero when time runs backwards.
    assign elapsed_w = (now_reg > last_reg) ? now_reg - last_reg : '0;

    // Accumulator limit: the larger of catch-up and period, never above the accumulator range.
    assign limit   = (catch_reg > CATCH_W'(period_reg)) ? catch_reg : CATCH_W'(period_reg);
    assign lim_eff = (LIM_W'(limit) > ACC_MAX_L) ? ACC_MAX_L : LIM_W'(limit);
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(elapsed_reg);
    assign acc_clamped = (acc_sum > SUM_W'(lim_eff)) ? ACC_BITS'(lim_eff) : ACC_BITS'(acc_sum);

    // Pending step count from the divider, saturated to its field.
    assign quot_ext      = QEXT_W'(div_quotient);
    assign pend_from_div = (quot_ext > QEXT_W'(PEND_MAX)) ? PEND_MAX : PEND_W'(quot_ext);

    // Accumulator against the period.
    assign acc_ge_period = AP_W'(acc_reg) >= AP_W'(period_reg);
    assign acc_minus     = ACC_BITS'(AP_W'(acc_reg) - AP_W'(period_reg));
    assign gap           = PERIOD_W'(AP_W'(period_reg) - AP_W'(acc_reg));

    // Scaled step length in Q28.8 (scale in Q8.8), zero while paused.
    assign scale_eff = paused_reg ? '0 : scale_reg;
    assign prod      = PROD_W'(period_reg) * PROD_W'(scale_eff);

    // Running totals with carry out for saturation.
    assign unscaled_sum = {1'b0, unscaled_tot_reg} + (TOTAL_W + 1)'(period_reg);
    assign scaled_sum   = {1'b0, scaled_tot_reg} + (TOTAL_W + 1)'(delta_reg);

    // Sequencer and register updates.
    always_comb
    begin
        state_next        = state_reg;
        period_next       = period_reg;
        catch_next        = catch_reg;
        scale_next        = scale_reg;
        paused_next       = paused_reg;
        acc_next          = acc_reg;
        pend_next         = pend_reg;
        last_next         = last_reg;
        due_next          = due_reg;
        scaled_tot_next   = scaled_tot_reg;
        unscaled_tot_next = unscaled_tot_reg;
        count_next        = count_reg;
        op_next           = op_reg;
        now_next          = now_reg;
        elapsed_next      = elapsed_reg;
        delta_next        = delta_reg;
        taken_next        = taken_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        // Configuration writes.
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_STEP_PERIOD:  period_next = wr_data[PERIOD_W-1:0];
                REG_MAX_CATCH_UP: catch_next  = wr_data[CATCH_W-1:0];
                REG_TIME_SCALE:   scale_next  = wr_data[SCALE_W-1:0];
                REG_PAUSED:       paused_next = wr_data[0];
                default:          ;
            endcase
        end

        // The consumer taking the stored item frees the output register.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    op_next    = tick.operation;
                    now_next   = TIME_BITS'(tick.now_us);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                taken_next = 1'b0;
                if (op_reg == OP_RESET)
                begin
                    acc_next   = '0;
                    pend_next  = '0;
                    last_next  = now_reg;
                    due_next   = (period_reg != '0) ? sat_add_time(now_reg, period_reg) : '0;
                    state_next = S_DONE;
                end
                else if (period_reg == '0)
                begin
                    acc_next   = '0;
                    pend_next  = '0;
                    last_next  = now_reg;
                    due_next   = '0;
                    state_next = S_DONE;
                end
                else if (pend_reg == '0)
                begin
                    elapsed_next = elapsed_w;
                    last_next    = now_reg;
                    if (paused_reg || scale_reg == '0)
                    begin
                        acc_next   = '0;
                        due_next   = sat_add_time(now_reg, period_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ACC;
                    end
                end
                else
                begin
                    state_next = S_FIRE;
                end
            end
            S_ACC:
            begin
                acc_next   = acc_clamped;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pend_next = pend_from_div;
                    if (pend_from_div == '0)
                    begin
                        due_next   = sat_add_time(now_reg, gap);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIRE;
                    end
                end
            end
            S_FIRE:
            begin
                pend_next  = pend_reg - 1'b1;
                acc_next   = acc_ge_period ? acc_minus : '0;
                delta_next = prod[PROD_W-1:PROD_W-DELTA_W];
                taken_next = 1'b1;
                state_next = S_DUE;
            end
            S_DUE:
            begin
                if (pend_reg != '0)
                begin
                    due_next = now_reg;
                end
                else
                begin
                    due_next = sat_add_time(now_reg, acc_ge_period ? '0 : gap);
                end
                unscaled_tot_next = unscaled_sum[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                          : unscaled_sum[TOTAL_W-1:0];
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                scaled_tot_next = scaled_sum[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                      : scaled_sum[TOTAL_W-1:0];
                count_next = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.step_taken       = taken_reg;
                    result_next.next_due_us      = NOW_W'(due_reg);
                    result_next.scaled_delta_us  = taken_reg ? delta_reg : '0;
                    result_next.game_time_us     = scaled_tot_reg;
                    result_next.unscaled_time_us = unscaled_tot_reg;
                    result_next.steps_left       = pend_reg;
                    result_next.step_count       = count_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            period_reg       <= PERIOD_RST;
            catch_reg        <= CATCH_RST;
            scale_reg        <= SCALE_RST;
            paused_reg       <= 1'b0;
            acc_reg          <= '0;
            pend_reg         <= '0;
            last_reg         <= '0;
            due_reg          <= '0;
            scaled_tot_reg   <= '0;
            unscaled_tot_reg <= '0;
            count_reg        <= '0;
            op_reg           <= 1'b0;
            now_reg          <= '0;
            elapsed_reg      <= '0;
            delta_reg        <= '0;
            taken_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            period_reg       <= period_next;
            catch_reg        <= catch_next;
            scale_reg        <= scale_next;
            paused_reg       <= paused_next;
            acc_reg          <= acc_next;
            pend_reg         <= pend_next;
            last_reg         <= last_next;
            due_reg          <= due_next;
            scaled_tot_reg   <= scaled_tot_next;
            unscaled_tot_reg <= unscaled_tot_next;
            count_reg        <= count_next;
            op_reg           <= op_next;
            now_reg          <= now_next;
            elapsed_reg      <= elapsed_next;
            delta_reg        <= delta_next;
            taken_reg        <= taken_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign tick_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("scheduler ready right after accepting an item");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside the wait state");

    // A fired step is always counted.
    a_step_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.step_taken |-> result.step_count != '0)
        else $error("step fired with zero step count");

    // No step, no delta.
    a_delta_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.step_taken |-> result.scaled_delta_us == '0)
        else $error("nonzero delta without a step");

    // Steps can be left over only from an event that fired one.
    a_left_implies_fired: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.steps_left != '0 |-> result.step_taken)
        else $error("steps left without a fired step");
`endif

endmodule
